FILE: rtl/core/sptk_pkg.sv
package sptk_pkg;

    // Request codes carried in the mode field.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;
    localparam logic [2:0] ST_ABSENT  = 3'd5;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_PATH_LIMIT = 3'd0;
    localparam logic [2:0] ADDR_PW_MAX     = 3'd4;

    localparam logic [15:0] PATH_LIMIT_RST = 16'd1024;
    localparam logic [31:0] PW_MAX_RST     = 32'd1048575;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] tunnel_id;
        logic [31:0] pw_id;
        logic [15:0] path_no;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  hit_index;
        logic [15:0] hit_path;
        logic [10:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] tunnel_id;
        logic [31:0] pw_id;
        logic [15:0] path_no;
    } t_entry;

endpackage

FILE: rtl/core/sorted_pair_key_table_top.sv
// Sorted table of (tunnel id, pseudowire id) keys, each with a path number.
// Requests enter on i_req with i_valid/o_ready and are taken when both are
// high. Each request is insert, delete or search (other modes get invalid)
// and yields exactly one response on o_rsp with o_valid/i_ready. The table
// is a single-port style memory (one write, one registered read per cycle)
// walked by a sequencer. A lookup is a binary search, each probe a read of
// the midpoint then a compare, and ends with a read and key check at the
// lower bound. Insert then moves every entry from the position up, delete
// every entry above it, by one slot, one entry per cycle. Checks that fail
// on the fields, a full table or an empty one skip the search. o_ready is
// high only while the sequencer is idle; a finished response sits in the
// output register, so a new request may be taken while the receiver stalls,
// and the next response waits until the register is free. Reset empties the
// table (the count goes to zero; memory contents are not cleared) and
// restores path_limit to 1024 and pw_max to 1048575. Configuration goes
// through the APB port: path_limit at byte address 0, pw_max at 4. The user
// must write them only while the block is idle; the block does not enforce it.
module sorted_pair_key_table_top
    import sptk_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_COMPARE,
        S_CHECK,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state          r_state;
    t_req            r_req;
    t_rsp            r_rsp;
    logic            r_out_valid;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_lo;
    logic [CW-1:0]   r_hi;
    logic [CW-1:0]   r_left;
    logic [AW-1:0]   r_rd_addr;
    logic [AW-1:0]   r_wr_addr;
    logic            r_wr_pend;
    logic [2:0]      r_status;
    logic [CW-1:0]   r_index;
    logic [15:0]     r_path;
    logic [15:0]     r_path_limit;
    logic [31:0]     r_pw_max;
    t_entry          r_rdata;
    t_entry          mem [DEPTH];

    logic            cfg_wr;
    logic            fields_ok;
    logic            full;
    logic [CW-1:0]   mid;
    logic            key_lt;
    logic            key_eq;
    logic            hit;
    logic            miss;
    logic            shift_end;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic            req_acc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign prdata  = paddr[2] ? r_pw_max : {16'd0, r_path_limit};
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;
    assign req_acc = i_valid & o_ready;

    assign fields_ok = (i_req.path_no < r_path_limit) && (i_req.pw_id <= r_pw_max);
    assign full      = (32'(r_count) >= 32'(r_path_limit)) || (32'(r_count) >= 32'(DEPTH));

    // Midpoint of the open search window.
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    // Stored key against the request key, tunnel id first.
    assign key_lt = {r_rdata.tunnel_id, r_rdata.pw_id} < {r_req.tunnel_id, r_req.pw_id};
    assign key_eq = {r_rdata.tunnel_id, r_rdata.pw_id} == {r_req.tunnel_id, r_req.pw_id};

    // The search ends with a hit only after the key check at the lower bound;
    // it misses either there or when the bound lands past the last entry.
    assign hit  = (r_state == S_CHECK) && key_eq;
    assign miss = ((r_state == S_CHECK) && !key_eq)
               || ((r_state == S_PROBE) && !(r_lo < r_hi) && !(r_lo < r_count));

    assign shift_end = (r_state == S_SHIFT) && (r_left == '0) && !r_wr_pend;

    always_comb begin
        mem_raddr = mid[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = r_rdata;
        case (r_state)
            S_PROBE: begin
                mem_raddr = (r_lo < r_hi) ? mid[AW-1:0] : r_lo[AW-1:0];
            end
            S_SHIFT: begin
                mem_raddr = r_rd_addr;
                if (r_wr_pend) begin
                    mem_we = 1'b1;
                end else if (shift_end && (r_req.mode == MODE_INSERT)) begin
                    // All moves are done: drop the new entry into the gap.
                    mem_we    = 1'b1;
                    mem_waddr = r_index[AW-1:0];
                    mem_wdata = '{tunnel_id: r_req.tunnel_id, pw_id: r_req.pw_id,
                                  path_no: r_req.path_no};
                end
            end
            default: begin
                mem_raddr = mid[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_left       <= '0;
            r_wr_pend    <= 1'b0;
            r_path_limit <= PATH_LIMIT_RST;
            r_pw_max     <= PW_MAX_RST;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_pw_max <= pwdata;
                end else begin
                    r_path_limit <= pwdata[15:0];
                end
            end

            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_req    <= i_req;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_status <= ST_OK;
                        r_index  <= '0;
                        r_path   <= '0;
                        r_state  <= S_PROBE;
                        case (i_req.mode)
                            MODE_INSERT: begin
                                if (!fields_ok) begin
                                    r_status <= ST_INVALID;
                                    r_state  <= S_DONE;
                                end else if (full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end
                            end
                            MODE_DELETE: begin
                                if (!fields_ok) begin
                                    r_status <= ST_INVALID;
                                    r_state  <= S_DONE;
                                end else if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end
                            end
                            MODE_SEARCH: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_status <= ST_INVALID;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PROBE: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_COMPARE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_COMPARE: begin
                    if (key_lt) begin
                        r_lo <= mid + 1'b1;
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= S_PROBE;
                end
                S_CHECK: begin
                    r_state <= S_DONE;
                end
                S_SHIFT: begin
                    if (r_left != '0) begin
                        r_left    <= r_left - 1'b1;
                        r_wr_pend <= 1'b1;
                        if (r_req.mode == MODE_DELETE) begin
                            r_rd_addr <= r_rd_addr + 1'b1;
                            r_wr_addr <= r_rd_addr - 1'b1;
                        end else begin
                            r_rd_addr <= r_rd_addr - 1'b1;
                            r_wr_addr <= r_rd_addr + 1'b1;
                        end
                    end else begin
                        r_wr_pend <= 1'b0;
                    end
                    if (shift_end) begin
                        if (r_req.mode == MODE_DELETE) begin
                            r_count <= r_count - 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid       <= 1'b1;
                        r_rsp.status      <= r_status;
                        r_rsp.hit_index   <= 10'(r_index);
                        r_rsp.hit_path    <= r_path;
                        r_rsp.entry_count <= 11'(r_count);
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Outcome of the search: set up the result and any entry moves.
            if (hit) begin
                r_index <= r_lo;
                r_path  <= r_rdata.path_no;
                case (r_req.mode)
                    MODE_INSERT: begin
                        r_status <= ST_PRESENT;
                        r_state  <= S_DONE;
                    end
                    MODE_DELETE: begin
                        // Pull every entry above the hit down by one slot.
                        r_rd_addr <= AW'(r_lo + 1'b1);
                        r_left    <= r_count - r_lo - 1'b1;
                        r_wr_pend <= 1'b0;
                        r_state   <= S_SHIFT;
                    end
                    default: begin
                        r_state <= S_DONE;
                    end
                endcase
            end else if (miss) begin
                if (r_req.mode == MODE_INSERT) begin
                    // Push entries from the top down to open a gap at r_lo.
                    r_index   <= r_lo;
                    r_path    <= r_req.path_no;
                    r_rd_addr <= AW'(r_count - 1'b1);
                    r_left    <= r_count - r_lo;
                    r_wr_pend <= 1'b0;
                    r_state   <= S_SHIFT;
                end else begin
                    r_status <= ST_ABSENT;
                    r_state  <= S_DONE;
                end
            end
        end
    end

    // The entry count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("entry count above depth");

    // A request changes the entry count by at most one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)
        || (r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

    // Once a request is taken the sequencer is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !o_ready)
        else $error("ready right after accept");

    // Entry moves are pending only while the shift runs.
    a_shift_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pend || (r_left != '0)) |-> (r_state == S_SHIFT))
        else $error("shift work outside shift state");

endmodule

FILE: dv/tb_sorted_pair_key_table_top.sv
`timescale 1ns / 1ps

module tb_sorted_pair_key_table_top;
    import sptk_pkg::*;

    // The block is built at its full depth. Most of the run keeps the table
    // small so that the shifting on insert and delete stays short.
    localparam int TB_DEPTH = 1024;

    // The mode field has one code that the block does not define.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Cycles that the block may still need for its slowest request.
    localparam int SETTLE_CYCLES = 2200;

    // Receiver hold-off used to back the block up against its input.
    localparam int HOLD_OFF_CYCLES = 400;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_req        i_req   = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_rsp        o_rsp;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    sorted_pair_key_table_top #(
        .DEPTH(TB_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rsp  (o_rsp),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the table contents and of the two limits. The limits
    // follow every register write, so they always match what the block holds.
    logic [31:0] tbl_tunnel [TB_DEPTH];
    logic [31:0] tbl_pw     [TB_DEPTH];
    logic [15:0] tbl_path   [TB_DEPTH];
    int unsigned tbl_count = 0;
    logic [15:0] lim_path  = PATH_LIMIT_RST;
    logic [31:0] lim_pw    = PW_MAX_RST;

    // Requests waiting to be offered, and the responses that the accepted
    // requests must produce, oldest first.
    t_req   req_backlog [$];
    t_rsp   rsp_due     [$];
    t_entry key_pool    [$];
    t_rsp   rsp_want;

    int mismatches   = 0;
    bit steady       = 1'b0;
    bit rx_hold_req  = 1'b0;
    int rx_hold_left = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
        end
    endtask

    // Ordering of keys: tunnel id first, pseudowire id breaks ties.
    function automatic bit key_below(input int unsigned i, input logic [31:0] t,
                                     input logic [31:0] p);
        return (tbl_tunnel[i] < t) || (tbl_tunnel[i] == t && tbl_pw[i] < p);
    endfunction

    // First slot whose key is not below (t, p); only slots below the count
    // are ever looked at.
    function automatic int unsigned key_position(input logic [31:0] t, input logic [31:0] p);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_below(mid, t, p)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Applies one request to the shadow table and returns the response the
    // block must give for it.
    function automatic t_rsp table_apply(input t_req r);
        t_rsp        rsp;
        logic        fields_ok;
        logic        hit;
        int unsigned pos;
        rsp       = '0;
        fields_ok = (r.path_no < lim_path) && (r.pw_id <= lim_pw);
        pos       = key_position(r.tunnel_id, r.pw_id);
        hit       = (pos < tbl_count) && (tbl_tunnel[pos] == r.tunnel_id)
                    && (tbl_pw[pos] == r.pw_id);
        case (r.mode)
            MODE_INSERT: begin
                if (!fields_ok) begin
                    rsp.status = ST_INVALID;
                end else if (tbl_count >= lim_path || tbl_count >= TB_DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (hit) begin
                    // A key that is already there keeps its old path number.
                    rsp.status    = ST_PRESENT;
                    rsp.hit_index = pos[9:0];
                    rsp.hit_path  = tbl_path[pos];
                end else begin
                    for (int unsigned i = tbl_count; i > pos; i--) begin
                        tbl_tunnel[i] = tbl_tunnel[i - 1];
                        tbl_pw[i]     = tbl_pw[i - 1];
                        tbl_path[i]   = tbl_path[i - 1];
                    end
                    tbl_tunnel[pos] = r.tunnel_id;
                    tbl_pw[pos]     = r.pw_id;
                    tbl_path[pos]   = r.path_no;
                    tbl_count++;
                    rsp.status    = ST_OK;
                    rsp.hit_index = pos[9:0];
                    rsp.hit_path  = r.path_no;
                end
            end
            MODE_DELETE: begin
                if (!fields_ok) begin
                    rsp.status = ST_INVALID;
                end else if (tbl_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (hit) begin
                    rsp.status    = ST_OK;
                    rsp.hit_index = pos[9:0];
                    rsp.hit_path  = tbl_path[pos];
                    for (int unsigned i = pos; i + 1 < tbl_count; i++) begin
                        tbl_tunnel[i] = tbl_tunnel[i + 1];
                        tbl_pw[i]     = tbl_pw[i + 1];
                        tbl_path[i]   = tbl_path[i + 1];
                    end
                    tbl_count--;
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
            MODE_SEARCH: begin
                // A search does not look at the limits at all.
                if (tbl_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (hit) begin
                    rsp.status    = ST_OK;
                    rsp.hit_index = pos[9:0];
                    rsp.hit_path  = tbl_path[pos];
                end else begin
                    rsp.status = ST_ABSENT;
                end
            end
            default: begin
                rsp.status = ST_INVALID;
            end
        endcase
        rsp.entry_count = tbl_count[10:0];
        return rsp;
    endfunction

    // Request driver. A request is predicted at the edge where it is taken,
    // and the next one is offered only once the current one is gone, so the
    // payload never changes while valid is high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                rsp_due.push_back(table_apply(i_req));
            end
            if (!i_valid || o_ready) begin
                if (req_backlog.size() != 0 && (steady || $urandom_range(99, 0) >= 30)) begin
                    i_req   <= req_backlog.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor. Every response taken is checked field by field
    // against the oldest one due. The receiver stalls at random, and once
    // holds off for a long stretch that it counts down itself.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("response with none due", 32'(o_rsp.status), '0);
                end else begin
                    rsp_want = rsp_due.pop_front();
                    if (o_rsp.status !== rsp_want.status) begin
                        report_mismatch("status", 32'(o_rsp.status),
                                        32'(rsp_want.status));
                    end
                    if (o_rsp.hit_index !== rsp_want.hit_index) begin
                        report_mismatch("hit_index", 32'(o_rsp.hit_index),
                                        32'(rsp_want.hit_index));
                    end
                    if (o_rsp.hit_path !== rsp_want.hit_path) begin
                        report_mismatch("hit_path", 32'(o_rsp.hit_path),
                                        32'(rsp_want.hit_path));
                    end
                    if (o_rsp.entry_count !== rsp_want.entry_count) begin
                        report_mismatch("entry_count", 32'(o_rsp.entry_count),
                                        32'(rsp_want.entry_count));
                    end
                end
            end
            if (rx_hold_req) begin
                rx_hold_left = HOLD_OFF_CYCLES;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99, 0) >= 30);
            end
        end
    end

    task automatic push_req(input logic [1:0] mode, input logic [31:0] t,
                            input logic [31:0] p, input logic [15:0] path);
        t_req r;
        r.mode      = mode;
        r.tunnel_id = t;
        r.pw_id     = p;
        r.path_no   = path;
        req_backlog.push_back(r);
    endtask

    // Waits at falling edges, where every update of the rising edge has
    // settled, until nothing is queued, in flight or due and the block is idle.
    task automatic drain();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || i_valid || rsp_due.size() != 0 || !o_ready) begin
            @(negedge i_clk);
        end
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PATH_LIMIT) begin
            lim_path = data[15:0];
        end else begin
            lim_pw = data;
        end
    endtask

    // Reads a register back; only the bits that the register holds count.
    task automatic reg_check(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_PATH_LIMIT) begin
            if (got[15:0] !== want[15:0]) begin
                report_mismatch("path_limit read", 32'(got[15:0]), 32'(want[15:0]));
            end
        end else if (got !== want) begin
            report_mismatch("pw_max read", got, want);
        end
    endtask

    // Called only while the block is idle.
    task automatic set_limits(input logic [15:0] path_lim, input logic [31:0] pw_lim);
        reg_write(ADDR_PATH_LIMIT, {16'd0, path_lim});
        reg_write(ADDR_PW_MAX, pw_lim);
        reg_check(ADDR_PATH_LIMIT, {16'd0, path_lim});
        reg_check(ADDR_PW_MAX, pw_lim);
    endtask

    // Tunnel ids cluster on a few small values and near the top, so that
    // many keys share a tunnel and the pseudowire id decides the order.
    function automatic logic [31:0] fresh_tunnel();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 40) begin
            return $urandom_range(3, 0);
        end else if (roll < 50) begin
            return 32'hFFFF_FFFF - $urandom_range(3, 0);
        end
        return $urandom();
    endfunction

    function automatic logic [31:0] fresh_pw();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (lim_pw == 0) begin
            return '0;
        end else if (roll < 40) begin
            return $urandom_range((lim_pw < 7) ? lim_pw : 7, 0);
        end else if (roll < 50) begin
            return lim_pw - $urandom_range((lim_pw < 3) ? lim_pw : 3, 0);
        end else if (lim_pw == 32'hFFFF_FFFF) begin
            return $urandom();
        end
        return $urandom_range(lim_pw, 0);
    endfunction

    function automatic logic [15:0] fresh_path();
        if ($urandom_range(9, 0) < 4) begin
            return 16'($urandom_range((lim_path < 4) ? lim_path - 1 : 3, 0));
        end
        return 16'($urandom_range(lim_path - 1, 0));
    endfunction

    // Mostly well-formed requests: inserts of new keys, deletes and searches
    // of keys that are in the table. The rest are duplicates, misses, bad
    // fields, the undefined mode and fully random requests.
    function automatic t_req random_request();
        t_req        r;
        int unsigned roll;
        int unsigned k;
        roll        = $urandom_range(99, 0);
        r.mode      = MODE_SEARCH;
        r.tunnel_id = fresh_tunnel();
        r.pw_id     = fresh_pw();
        r.path_no   = fresh_path();
        if (roll < 45) begin
            r.mode = MODE_INSERT;
            if (key_pool.size() != 0 && $urandom_range(9, 0) == 0) begin
                k           = $urandom_range(key_pool.size() - 1, 0);
                r.tunnel_id = key_pool[k].tunnel_id;
                r.pw_id     = key_pool[k].pw_id;
            end else begin
                key_pool.push_back('{r.tunnel_id, r.pw_id, r.path_no});
            end
        end else if (roll < 65) begin
            r.mode = MODE_DELETE;
            if (key_pool.size() != 0 && $urandom_range(4, 0) != 0) begin
                k           = $urandom_range(key_pool.size() - 1, 0);
                r.tunnel_id = key_pool[k].tunnel_id;
                r.pw_id     = key_pool[k].pw_id;
                key_pool.delete(k);
            end
        end else if (roll < 90) begin
            if (key_pool.size() != 0 && $urandom_range(9, 0) < 7) begin
                k           = $urandom_range(key_pool.size() - 1, 0);
                r.tunnel_id = key_pool[k].tunnel_id;
                r.pw_id     = key_pool[k].pw_id;
            end
        end else begin
            case ($urandom_range(3, 0))
                0: begin
                    r.mode      = MODE_UNUSED;
                    r.tunnel_id = $urandom();
                    r.pw_id     = $urandom();
                    r.path_no   = 16'($urandom());
                end
                1: begin
                    r.mode    = ($urandom_range(1, 0) == 0) ? MODE_INSERT : MODE_DELETE;
                    r.path_no = 16'($urandom_range(16'hFFFF, lim_path));
                end
                2: begin
                    r.mode = ($urandom_range(1, 0) == 0) ? MODE_INSERT : MODE_DELETE;
                    if (lim_pw != 32'hFFFF_FFFF) begin
                        r.pw_id = $urandom_range(32'hFFFF_FFFF, lim_pw + 1);
                    end else begin
                        r.path_no = 16'($urandom_range(16'hFFFF, lim_path));
                    end
                end
                default: begin
                    r.mode      = 2'($urandom_range(3, 0));
                    r.tunnel_id = $urandom();
                    r.pw_id     = $urandom();
                    r.path_no   = 16'($urandom());
                end
            endcase
        end
        return r;
    endfunction

    // One phase of random traffic at the current limits. The key pool starts
    // from the exact table contents, which are settled while the block idles.
    task automatic random_phase(input int n_items, input bit quiet, input bit hold_rx);
        key_pool.delete();
        for (int unsigned i = 0; i < tbl_count; i++) begin
            key_pool.push_back('{tbl_tunnel[i], tbl_pw[i], tbl_path[i]});
        end
        for (int i = 0; i < n_items; i++) begin
            req_backlog.push_back(random_request());
        end
        steady      = quiet;
        rx_hold_req = hold_rx;
        drain();
        steady = 1'b0;
    endtask

    // Empties the table with permissive limits, last entry first so that
    // no delete has to shift anything.
    task automatic flush_table();
        set_limits(16'hFFFF, 32'hFFFF_FFFF);
        for (int i = int'(tbl_count) - 1; i >= 0; i--) begin
            push_req(MODE_DELETE, tbl_tunnel[i], tbl_pw[i], 16'd0);
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();
        reg_check(ADDR_PATH_LIMIT, {16'd0, PATH_LIMIT_RST});
        reg_check(ADDR_PW_MAX, PW_MAX_RST);

        // Directed requests at the reset limits: the empty table, keys at
        // both ends of the range, two keys on one tunnel, a duplicate insert,
        // fields just over each limit, the undefined mode, a search that
        // ignores the limits, and a miss after a delete.
        push_req(MODE_SEARCH, 32'd0, 32'd0, 16'd0);
        push_req(MODE_DELETE, 32'd0, 32'd0, 16'd0);
        push_req(MODE_INSERT, 32'd0, 32'd0, 16'd0);
        push_req(MODE_INSERT, 32'hFFFF_FFFF, PW_MAX_RST, PATH_LIMIT_RST - 16'd1);
        push_req(MODE_INSERT, 32'd5, 32'd7, 16'd1);
        push_req(MODE_INSERT, 32'd5, 32'd3, 16'd2);
        push_req(MODE_INSERT, 32'd5, 32'd7, 16'd9);
        push_req(MODE_INSERT, 32'd6, 32'd1, PATH_LIMIT_RST);
        push_req(MODE_INSERT, 32'd6, PW_MAX_RST + 32'd1, 16'd0);
        push_req(MODE_INSERT, 32'd6, 32'd1, 16'hFFFF);
        push_req(MODE_DELETE, 32'd5, 32'd7, 16'hFFFF);
        push_req(MODE_UNUSED, 32'd5, 32'd7, 16'd1);
        push_req(MODE_SEARCH, 32'd5, 32'd3, 16'd0);
        push_req(MODE_SEARCH, 32'd5, 32'd4, 16'd0);
        push_req(MODE_SEARCH, 32'd5, 32'hFFFF_FFFF, 16'hFFFF);
        push_req(MODE_DELETE, 32'd5, 32'd7, 16'd0);
        push_req(MODE_DELETE, 32'd5, 32'd7, 16'd0);
        push_req(MODE_SEARCH, 32'hFFFF_FFFF, PW_MAX_RST, 16'd0);
        push_req(MODE_DELETE, 32'd0, 32'd0, 16'd0);
        drain();

        // The smallest path limit: two entries already exceed it, so the
        // table counts as full until it is emptied, and again once one entry is in.
        set_limits(16'd1, PW_MAX_RST);
        push_req(MODE_INSERT, 32'd9, 32'd9, 16'd0);
        push_req(MODE_DELETE, 32'd5, 32'd3, 16'd1);
        push_req(MODE_DELETE, 32'd5, 32'd3, 16'd0);
        push_req(MODE_DELETE, 32'hFFFF_FFFF, PW_MAX_RST, 16'd0);
        push_req(MODE_INSERT, 32'd9, 32'd9, 16'd0);
        push_req(MODE_INSERT, 32'd10, 32'd1, 16'd0);
        drain();

        // Random traffic over several limit settings. The first phase runs
        // without any idling; the second backs the block up behind a long
        // receiver stall while the sender keeps offering requests.
        set_limits(PATH_LIMIT_RST, PW_MAX_RST);
        random_phase(120, 1'b1, 1'b0);
        set_limits(16'hFFFF, 32'hFFFF_FFFF);
        random_phase(130, 1'b0, 1'b1);
        set_limits(16'd16, 32'hFFFF_FFFF);
        random_phase(90, 1'b0, 1'b0);
        set_limits(16'd1, 32'h0000_FFFF);
        random_phase(40, 1'b0, 1'b0);
        flush_table();
        set_limits(16'd5, 32'd0);
        random_phase(60, 1'b0, 1'b0);
        set_limits(16'd300, 32'h7FFF_FFFF);
        random_phase(70, 1'b0, 1'b0);

        // Let any stray response show up before the verdict.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (rsp_due.size() != 0) begin
            report_mismatch("responses still due", rsp_due.size(), '0);
        end
        if (mismatches == 0) begin
            $display("tb_sorted_pair_key_table_top passed");
        end else begin
            $display("tb_sorted_pair_key_table_top failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every request shifting
    // a full table behind the longest stalls.
    initial begin
        #(60_000_000);
        $display("tb_sorted_pair_key_table_top failed");
        $finish;
    end

endmodule
